/* design/assert_macros.svh */
// Assertion macros used by the checker file of the rotation core.
// No dependencies; pulled in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/qpr_pkg.sv */
// Shared types and constants of the quaternion point rotation core.
// No dependencies; imported by every module of the block.
package qpr_pkg;

  // Field widths
  localparam int PT_W   = 32;  // Q16.16 coordinate
  localparam int QC_W   = 16;  // Q2.14 quaternion component
  localparam int COL_W  = 8;
  localparam int Q_FRAC = 14;

  // Datapath widths of the two quaternion products
  localparam int PROD1_W = PT_W + QC_W;       // coordinate * component
  localparam int SUM1_W  = PROD1_W + 1;       // sum of three products
  localparam int T_W     = SUM1_W - Q_FRAC;   // intermediate quaternion
  localparam int PROD2_W = T_W + QC_W;        // component * intermediate
  localparam int SUM2_W  = PROD2_W + 2;       // sum of four products
  localparam int R_W     = SUM2_W - Q_FRAC;   // rotated, before clamping

  localparam int ROUND_HALF = 1 << (Q_FRAC - 1);

  // Stream and config widths
  localparam int IN_DATA_W  = 3 * PT_W + 3 * COL_W;
  localparam int OUT_DATA_W = 3 * PT_W + 3 * COL_W;
  localparam int CFG_IDX_W  = 8;

  localparam logic [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

  localparam logic [QC_W-1:0] QUAT_ONE = QC_W'(1 << Q_FRAC);

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUAT_X = 8'd0,
    CFG_QUAT_Y = 8'd1,
    CFG_QUAT_Z = 8'd2,
    CFG_QUAT_W = 8'd3
  } qpr_cfg_idx_t;

  typedef struct packed {
    logic [QC_W-1:0] x;
    logic [QC_W-1:0] y;
    logic [QC_W-1:0] z;
    logic [QC_W-1:0] w;
  } qpr_quat_t;

  typedef struct packed {
    logic [T_W-1:0] x;
    logic [T_W-1:0] y;
    logic [T_W-1:0] z;
    logic [T_W-1:0] w;
  } qpr_tquat_t;

  // Load enables of the two register stages inside one product unit
  typedef struct packed {
    logic first;
    logic second;
  } qpr_stage_en_t;

endpackage

/* design/quaternion_point_rotation_core.sv */
// Quaternion point rotation core: rotates each Q16.16 point by the configured
// Q2.14 quaternion q as q * (P * conj(q)) and passes its colour bytes along.
// The datapath is four register stages (two per quaternion product: partial
// products, then sum and round), and one point is accepted every cycle while
// the output is taken. A stalled output back-fills empty stages before input
// is held. q is not normalized; results beyond the signed 32-bit range are
// clamped and flagged in tuser. Configuration writes are taken at once
// (cfg_ready is always high) and must only be made while the pipeline is
// empty.
// Depends on qpr_pkg, qpr_conj_mul and qpr_quat_mul.
module quaternion_point_rotation_core
  import qpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // point_x, point_y, point_z, red_in, green_in, blue_in (from bit 0 up)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // rotated_x, rotated_y, rotated_z, red_out, green_out, blue_out (bit 0 up)
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // overflow
  output logic [0:0]            m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [QC_W-1:0]       cfg_data
);

  localparam int STAGES = 4;

  qpr_quat_t          quat;
  logic [STAGES-1:0]  valid;
  logic [STAGES-1:0]  advance;
  logic [3*COL_W-1:0] colour [STAGES];
  qpr_stage_en_t      en_conj;
  qpr_stage_en_t      en_quat;
  qpr_tquat_t         tq;
  logic [PT_W-1:0]    rotated_x, rotated_y, rotated_z;
  logic               overflow;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
      quat.w <= QUAT_ONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_QUAT_X: quat.x <= cfg_data;
        CFG_QUAT_Y: quat.y <= cfg_data;
        CFG_QUAT_Z: quat.z <= cfg_data;
        CFG_QUAT_W: quat.w <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on
  always_comb begin
    advance[STAGES-1] = !valid[STAGES-1] || m_axis_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      advance[i] = !valid[i] || advance[i+1];
    end
  end

  assign s_axis_tready = advance[0];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (advance[0]) valid[0] <= s_axis_tvalid;
      for (int i = 1; i < STAGES; i++) begin
        if (advance[i]) valid[i] <= valid[i-1];
      end
    end
  end

  // Carry the colour bytes alongside the arithmetic
  always_ff @(posedge clk) begin
    if (advance[0]) colour[0] <= s_axis_tdata[IN_DATA_W-1:3*PT_W];
    for (int i = 1; i < STAGES; i++) begin
      if (advance[i]) colour[i] <= colour[i-1];
    end
  end

  assign en_conj.first  = advance[0];
  assign en_conj.second = advance[1];
  assign en_quat.first  = advance[2];
  assign en_quat.second = advance[3];

  qpr_conj_mul u_conj_mul (
    .clk     (clk),
    .en      (en_conj),
    .point_x (s_axis_tdata[PT_W-1:0]),
    .point_y (s_axis_tdata[2*PT_W-1:PT_W]),
    .point_z (s_axis_tdata[3*PT_W-1:2*PT_W]),
    .quat    (quat),
    .tq      (tq)
  );

  qpr_quat_mul u_quat_mul (
    .clk       (clk),
    .en        (en_quat),
    .quat      (quat),
    .tq        (tq),
    .rotated_x (rotated_x),
    .rotated_y (rotated_y),
    .rotated_z (rotated_z),
    .overflow  (overflow)
  );

  // Output beat
  assign m_axis_tvalid   = valid[STAGES-1];
  assign m_axis_tdata    = {colour[STAGES-1], rotated_z, rotated_y, rotated_x};
  assign m_axis_tuser[0] = overflow;

endmodule

/* design/qpr_conj_mul.sv */
// Point times conjugate quaternion, T = P * conj(q), in two register stages.
// Depends on qpr_pkg.
module qpr_conj_mul
  import qpr_pkg::*;
(
  input  logic            clk,
  input  qpr_stage_en_t   en,
  input  logic [PT_W-1:0] point_x,
  input  logic [PT_W-1:0] point_y,
  input  logic [PT_W-1:0] point_z,
  input  qpr_quat_t       quat,
  output qpr_tquat_t      tq
);

  logic signed [PT_W-1:0]    px, py, pz;
  logic signed [QC_W-1:0]    qx, qy, qz, qw;
  logic signed [PROD1_W-1:0] prod [12];
  logic signed [SUM1_W-1:0]  sx, sy, sz, sw;
  logic signed [SUM1_W-1:0]  half;

  assign px   = point_x;
  assign py   = point_y;
  assign pz   = point_z;
  assign qx   = quat.x;
  assign qy   = quat.y;
  assign qz   = quat.z;
  assign qw   = quat.w;
  assign half = SUM1_W'(ROUND_HALF);

  // Stage one: register the twelve partial products
  always_ff @(posedge clk) begin
    if (en.first) begin
      prod[0]  <= px * qw;
      prod[1]  <= py * qz;
      prod[2]  <= pz * qy;
      prod[3]  <= py * qw;
      prod[4]  <= pz * qx;
      prod[5]  <= px * qz;
      prod[6]  <= pz * qw;
      prod[7]  <= px * qy;
      prod[8]  <= py * qx;
      prod[9]  <= px * qx;
      prod[10] <= py * qy;
      prod[11] <= pz * qz;
    end
  end

  // Sum with the half-LSB bias; flooring shift is taking the upper bits
  always_comb begin
    sx = prod[0] - prod[1] + prod[2] + half;
    sy = prod[3] - prod[4] + prod[5] + half;
    sz = prod[6] - prod[7] + prod[8] + half;
    sw = prod[9] + prod[10] + prod[11] + half;
  end

  // Stage two: register the rounded intermediate quaternion
  always_ff @(posedge clk) begin
    if (en.second) begin
      tq.x <= sx[SUM1_W-1:Q_FRAC];
      tq.y <= sy[SUM1_W-1:Q_FRAC];
      tq.z <= sz[SUM1_W-1:Q_FRAC];
      tq.w <= sw[SUM1_W-1:Q_FRAC];
    end
  end

endmodule

/* design/qpr_quat_mul.sv */
// Quaternion times intermediate, R = q * T, vector part, rounded and clamped.
// Two register stages; depends on qpr_pkg.
module qpr_quat_mul
  import qpr_pkg::*;
(
  input  logic            clk,
  input  qpr_stage_en_t   en,
  input  qpr_quat_t       quat,
  input  qpr_tquat_t      tq,
  output logic [PT_W-1:0] rotated_x,
  output logic [PT_W-1:0] rotated_y,
  output logic [PT_W-1:0] rotated_z,
  output logic            overflow
);

  logic signed [QC_W-1:0]    qx, qy, qz, qw;
  logic signed [T_W-1:0]     tx, ty, tz, tw;
  logic signed [PROD2_W-1:0] prod [12];
  logic signed [SUM2_W-1:0]  sx, sy, sz;
  logic signed [SUM2_W-1:0]  half;
  logic signed [R_W-1:0]     rx, ry, rz;
  logic                      ovx, ovy, ovz;

  assign qx   = quat.x;
  assign qy   = quat.y;
  assign qz   = quat.z;
  assign qw   = quat.w;
  assign tx   = tq.x;
  assign ty   = tq.y;
  assign tz   = tq.z;
  assign tw   = tq.w;
  assign half = SUM2_W'(ROUND_HALF);

  // Stage three: register the twelve partial products
  always_ff @(posedge clk) begin
    if (en.first) begin
      prod[0]  <= qw * tx;
      prod[1]  <= qx * tw;
      prod[2]  <= qy * tz;
      prod[3]  <= qz * ty;
      prod[4]  <= qw * ty;
      prod[5]  <= qy * tw;
      prod[6]  <= qz * tx;
      prod[7]  <= qx * tz;
      prod[8]  <= qw * tz;
      prod[9]  <= qz * tw;
      prod[10] <= qx * ty;
      prod[11] <= qy * tx;
    end
  end

  // Sum, round half up, then check the bits above the output range
  always_comb begin
    sx  = prod[0] + prod[1] + prod[2] - prod[3] + half;
    sy  = prod[4] + prod[5] + prod[6] - prod[7] + half;
    sz  = prod[8] + prod[9] + prod[10] - prod[11] + half;
    rx  = sx[SUM2_W-1:Q_FRAC];
    ry  = sy[SUM2_W-1:Q_FRAC];
    rz  = sz[SUM2_W-1:Q_FRAC];
    ovx = (rx[R_W-1:PT_W-1] != {(R_W-PT_W+1){rx[R_W-1]}});
    ovy = (ry[R_W-1:PT_W-1] != {(R_W-PT_W+1){ry[R_W-1]}});
    ovz = (rz[R_W-1:PT_W-1] != {(R_W-PT_W+1){rz[R_W-1]}});
  end

  // Stage four: clamp into the output register
  always_ff @(posedge clk) begin
    if (en.second) begin
      rotated_x <= ovx ? (rx[R_W-1] ? PT_MIN : PT_MAX) : rx[PT_W-1:0];
      rotated_y <= ovy ? (ry[R_W-1] ? PT_MIN : PT_MAX) : ry[PT_W-1:0];
      rotated_z <= ovz ? (rz[R_W-1] ? PT_MIN : PT_MAX) : rz[PT_W-1:0];
      overflow  <= ovx | ovy | ovz;
    end
  end

endmodule

/* design/qpr_checker.sv */
// Port-level checks of the quaternion point rotation core, bound to the top.
// Depends on qpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qpr_checker
  import qpr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready
);

  logic clamped;

  // Some coordinate of the output beat sits at a clamp limit
  assign clamped = (m_axis_tdata[PT_W-1:0] == PT_MAX) ||
                   (m_axis_tdata[PT_W-1:0] == PT_MIN) ||
                   (m_axis_tdata[2*PT_W-1:PT_W] == PT_MAX) ||
                   (m_axis_tdata[2*PT_W-1:PT_W] == PT_MIN) ||
                   (m_axis_tdata[3*PT_W-1:2*PT_W] == PT_MAX) ||
                   (m_axis_tdata[3*PT_W-1:2*PT_W] == PT_MIN);

  // Reset empties the pipeline
  `ASSERT_CLK_NR(a_reset_empty, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // A stalled beat holds
  `ASSERT_CLK(a_stall_hold, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
    "stalled output beat changed")

  // An empty or draining output stage never blocks the input
  `ASSERT_CLK(a_no_block, clk, rst, !m_axis_tvalid || m_axis_tready |-> s_axis_tready,
    "input stalled while output stage free")

  // The overflow flag comes only with a clamped coordinate
  `ASSERT_CLK(a_ovf_clamp, clk, rst, m_axis_tvalid && m_axis_tuser[0] |-> clamped,
    "overflow without clamped coordinate")

endmodule

bind quaternion_point_rotation_core qpr_checker u_qpr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
